@@ rtl/u8u16_pkg.sv @@
`timescale 1ns / 1ps
package u8u16_pkg;

  localparam logic [7:0]  CONT_MASK    = 8'hc0;
  localparam logic [7:0]  CONT_TAG     = 8'h80;
  localparam logic [30:0] SURR_LO      = 31'h0000d800;
  localparam logic [30:0] BMP_HI_START = 31'h0000e000;
  localparam logic [30:0] BMP_LAST     = 31'h0000ffff;
  localparam logic [30:0] SUPP_FIRST   = 31'h00010000;
  localparam logic [30:0] SUPP_LAST    = 31'h0010ffff;
  localparam logic [30:0] BOM_CODE     = 31'h0000feff;
  localparam logic [15:0] HI_SURR_BASE = 16'hd800;
  localparam logic [15:0] LO_SURR_BASE = 16'hdc00;
  localparam logic [2:0]  BOM_LEN      = 3'd3;

  // results caused by one byte: one unit, a surrogate pair, or an error
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        err;
    logic        two;
  } grp_t;

  // sequence length set by a lead byte, zero for a bad lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    begin
      if (b < 8'h80)      n = 3'd1;
      else if (b < 8'hc0) n = 3'd0;
      else if (b < 8'he0) n = 3'd2;
      else if (b < 8'hf0) n = 3'd3;
      else if (b < 8'hf8) n = 3'd4;
      else if (b < 8'hfc) n = 3'd5;
      else if (b < 8'hfe) n = 3'd6;
      else                n = 3'd0;
      return n;
    end
  endfunction

  // payload bits a lead byte keeps
  function automatic logic [7:0] lead_keep(input logic [2:0] n);
    logic [7:0] m;
    begin
      case (n)
        3'd1:    m = 8'h7f;
        3'd2:    m = 8'h1f;
        3'd3:    m = 8'h0f;
        3'd4:    m = 8'h07;
        3'd5:    m = 8'h03;
        3'd6:    m = 8'h01;
        default: m = 8'h00;
      endcase
      return m;
    end
  endfunction

endpackage

@@ rtl/utf8_to_utf16_converter_unit.sv @@
`timescale 1ns / 1ps
// utf-8 to utf-16 transcoder
// input channel: one utf-8 byte per beat (in_data_byte), in_end_of_string
//   marks the final byte of a string and returns the decoder to idle
// result channel: one utf-16 code unit per beat, out_error flags a malformed
//   string (unit is zero then), out_last_of_run marks the final beat that a
//   given input byte caused; a supplementary code gives two beats, high first
// a byte is decoded in the cycle it is accepted; its results are registered
//   in the output register, or in the skid register while the receiver
//   stalls; a byte that gives one unit sustains one beat per cycle while
//   out_stall is low; bytes that give no result (non-final continuations,
//   byte-order mark, discarded bytes) never occupy the output
// a one-group skid register behind the output register lets one more byte
//   be accepted while the receiver stalls; in_stall rises once that is full
// after an error, bytes are dropped until end of string
// reset (rst_n low, synchronous) clears the decoder state and empties both
//   result registers
module utf8_to_utf16_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_error,
  output logic        out_last_of_run
);
  import u8u16_pkg::*;

  // decoder state
  logic [2:0]  rem_r, rem_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        disc_r, disc_nxt;

  // output register and skid register
  logic        o_valid_r, o_valid_nxt;
  logic        o_idx_r, o_idx_nxt;
  grp_t        o_grp_r, o_grp_nxt;
  logic        b_valid_r, b_valid_nxt;
  grp_t        b_grp_r, b_grp_nxt;

  logic        in_fire;
  logic [2:0]  ll;
  logic        err_seq;
  logic        err_eos;
  logic        fin;
  logic        bom;
  logic        is_single;
  logic        is_pair;
  logic        has_res;
  logic [19:0] fin_code;
  logic [19:0] supp_off;
  grp_t        new_grp;
  logic        o_done;
  logic        o_free;

  assign in_stall = b_valid_r;
  assign in_fire  = in_valid & ~b_valid_r;
  assign ll       = lead_len(in_data_byte);

  // byte decode, same cycle as acceptance
  always_comb begin
    rem_nxt  = rem_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    disc_nxt = disc_r;
    err_seq  = 1'b0;
    fin      = 1'b0;
    if (disc_r) begin
      // drop
    end else if (rem_r == 3'd0) begin
      if (in_data_byte == 8'h00) begin
        disc_nxt = 1'b1;  // string terminator
      end else if (ll == 3'd0) begin
        err_seq = 1'b1;
      end else begin
        len_nxt = ll;
        acc_nxt = {23'd0, in_data_byte & lead_keep(ll)};
        rem_nxt = ll - 3'd1;
        fin     = (ll == 3'd1);
      end
    end else if ((in_data_byte & CONT_MASK) != CONT_TAG) begin
      err_seq = 1'b1;
    end else begin
      acc_nxt = {acc_r[24:0], in_data_byte[5:0]};
      rem_nxt = rem_r - 3'd1;
      fin     = (rem_r == 3'd1);
    end

    // finished code, kept apart from the end-of-string clear below
    fin_code = acc_nxt[19:0];

    // classify a finished code
    bom       = fin && (len_nxt == BOM_LEN) && (acc_nxt == BOM_CODE);
    is_single = fin && !bom &&
                ((acc_nxt < SURR_LO) || ((acc_nxt >= BMP_HI_START) && (acc_nxt <= BMP_LAST)));
    is_pair   = fin && !bom && (acc_nxt >= SUPP_FIRST) && (acc_nxt <= SUPP_LAST);
    if (fin && !bom && !is_single && !is_pair) begin
      err_seq = 1'b1;
    end
    if (err_seq) begin
      disc_nxt  = 1'b1;
      rem_nxt   = 3'd0;
      is_single = 1'b0;
      is_pair   = 1'b0;
    end

    // string ends with continuation bytes still expected
    err_eos = in_end_of_string && !disc_nxt && (rem_nxt != 3'd0);
    if (in_end_of_string) begin
      rem_nxt  = 3'd0;
      len_nxt  = 3'd0;
      acc_nxt  = '0;
      disc_nxt = 1'b0;
    end
  end

  always_comb begin
    supp_off      = fin_code - SUPP_FIRST[19:0];
    new_grp.err   = err_seq | err_eos;
    new_grp.two   = is_pair;
    new_grp.unit0 = '0;
    new_grp.unit1 = LO_SURR_BASE | {6'd0, supp_off[9:0]};
    if (is_pair) begin
      new_grp.unit0 = HI_SURR_BASE | {6'd0, supp_off[19:10]};
    end else if (is_single) begin
      new_grp.unit0 = fin_code[15:0];
    end
    has_res = err_seq | err_eos | is_single | is_pair;
  end

  // output side
  assign out_valid       = o_valid_r;
  assign out_code_unit   = o_idx_r ? o_grp_r.unit1 : o_grp_r.unit0;
  assign out_error       = o_grp_r.err;
  assign out_last_of_run = ~o_grp_r.two | o_idx_r;

  assign o_done = o_valid_r & ~out_stall & out_last_of_run;
  assign o_free = ~o_valid_r | o_done;

  always_comb begin
    o_valid_nxt = o_valid_r;
    o_idx_nxt   = o_idx_r;
    o_grp_nxt   = o_grp_r;
    b_valid_nxt = b_valid_r;
    b_grp_nxt   = b_grp_r;
    if (o_valid_r && !out_stall && !out_last_of_run) begin
      o_idx_nxt = 1'b1;  // high surrogate taken, show the low one
    end
    if (o_free) begin
      o_idx_nxt = 1'b0;
      if (b_valid_r) begin
        o_valid_nxt = 1'b1;
        o_grp_nxt   = b_grp_r;
        b_valid_nxt = 1'b0;
      end else if (in_fire && has_res) begin
        o_valid_nxt = 1'b1;
        o_grp_nxt   = new_grp;
      end else begin
        o_valid_nxt = 1'b0;
      end
    end else if (in_fire && has_res) begin
      b_valid_nxt = 1'b1;
      b_grp_nxt   = new_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      len_r     <= '0;
      acc_r     <= '0;
      disc_r    <= 1'b0;
      o_valid_r <= 1'b0;
      o_idx_r   <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        rem_r  <= rem_nxt;
        len_r  <= len_nxt;
        acc_r  <= acc_nxt;
        disc_r <= disc_nxt;
      end
      o_valid_r <= o_valid_nxt;
      o_idx_r   <= o_idx_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    o_grp_r <= o_grp_nxt;
    b_grp_r <= b_grp_nxt;
  end

endmodule

@@ rtl/u8u16_checker.sv @@
`timescale 1ns / 1ps
module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_code_unit,
  input logic        out_error,
  input logic        out_last_of_run
);

  // a stalled beat stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // error beats carry a zero unit and close the byte's run
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_code_unit == 16'h0000 && out_last_of_run)
    else $error("malformed error beat");

  // only a high surrogate is followed by another beat of the same byte
  a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_code_unit[15:10] == 6'b110110 && !out_error)
    else $error("non-final beat is not a high surrogate");

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind utf8_to_utf16_converter_unit u8u16_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_code_unit   (out_code_unit),
  .out_error       (out_error),
  .out_last_of_run (out_last_of_run)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// utf-8 to utf-16 transcoder testbench
// bytes go in on the input channel, units are checked on the output channel
// against a decoder model kept in this file, or hand-written units for typed rows
module tb_top;
  import u8u16_pkg::*;

  // cycles with no beat on either channel before the run is called hung
  localparam int QUIET_LIMIT = 5000;
  // receiver hold-off at the start of the random part, fills the skid
  localparam int LONG_HOLD = 300;
  // random part length in input bytes, first few sent back to back
  localparam int RAND_BYTES = 900;
  localparam int BURST_BYTES = 150;

  // one utf-16 unit as it leaves the block
  typedef struct packed {
    logic [15:0] unit;
    logic        err;
    logic        last;
  } unit_beat_t;

  // directed row: byte, end flag, and a typed expectation where it is obvious
  typedef struct packed {
    logic [7:0]  b;
    logic        eos;
    logic        typed;
    logic [1:0]  n;
    logic [15:0] u0;
    logic [15:0] u1;
    logic        err;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // plain ascii, a letter and the highest code
    '{8'h41, 1'b0, 1'b1, 2'd1, 16'h0041, 16'h0000, 1'b0},
    '{8'h7f, 1'b0, 1'b1, 2'd1, 16'h007f, 16'h0000, 1'b0},
    // two-byte sequence, first code that needs it
    '{8'hc2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    // byte-order mark in mid string is dropped
    '{8'hef, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'hbb, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'hbf, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 1'b0},
    // lowest supplementary code, surrogate pair
    '{8'hf0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'h90, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b1, 2'd2, 16'hd800, 16'hdc00, 1'b0},
    // highest legal code, string ends right on it
    '{8'hf4, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'h8f, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'hbf, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'hbf, 1'b1, 1'b1, 2'd2, 16'hdbff, 16'hdfff, 1'b0},
    // encoded surrogate is out of range, rest of string dropped
    '{8'hed, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'ha0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000, 1'b1},
    '{8'h41, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000, 1'b0},
    // bad lead
    '{8'hfe, 1'b1, 1'b1, 2'd1, 16'h0000, 16'h0000, 1'b1},
    // zero where a continuation belongs
    '{8'hc2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'h00, 1'b1, 1'b1, 2'd1, 16'h0000, 16'h0000, 1'b1},
    // terminator, bytes after it are silent
    '{8'h00, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 1'b0},
    '{8'h41, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000, 1'b0},
    // string ends inside a sequence
    '{8'he2, 1'b1, 1'b1, 2'd1, 16'h0000, 16'h0000, 1'b1},
    // stray continuation as lead
    '{8'hbf, 1'b1, 1'b1, 2'd1, 16'h0000, 16'h0000, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_error;
  logic        out_last_of_run;

  // tags that travel with the byte on the input side
  logic cur_typed = 1'b0;
  int   cur_row = 0;

  // decoder model state
  logic [2:0]  rem_cont = 3'd0;
  logic [2:0]  seq_len = 3'd0;
  logic [30:0] code_acc = 31'd0;
  logic        dropping = 1'b0;

  unit_beat_t step_out[$];       // units from the byte just decoded
  unit_beat_t pending_units[$];  // units still owed by the block
  int quiet_cycles = 0;
  int mismatches = 0;
  logic hold_go = 1'b0;

  utf8_to_utf16_converter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_unit    (out_code_unit),
    .out_error        (out_error),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // append one unit to the current byte's results
  function automatic void add_unit(input logic [15:0] u, input logic e);
    unit_beat_t ub;
    ub.unit = u;
    ub.err  = e;
    ub.last = 1'b0;
    step_out.insert(step_out.size(), ub);
  endfunction

  // malformed string: one error unit, drop the rest of the string
  function automatic void note_error();
    add_unit(16'h0000, 1'b1);
    dropping = 1'b1;
    rem_cont = 3'd0;
  endfunction

  // a code point is complete: one unit, a pair, nothing (bom) or an error
  function automatic void close_code();
    logic [30:0] v;
    if (seq_len == BOM_LEN && code_acc == BOM_CODE) return;
    if (code_acc < SURR_LO || (code_acc >= BMP_HI_START && code_acc <= BMP_LAST)) begin
      add_unit(code_acc[15:0], 1'b0);
    end else if (code_acc >= SUPP_FIRST && code_acc <= SUPP_LAST) begin
      v = code_acc - SUPP_FIRST;
      add_unit(HI_SURR_BASE | {6'd0, v[19:10]}, 1'b0);
      add_unit(LO_SURR_BASE | {6'd0, v[9:0]}, 1'b0);
    end else begin
      note_error();
    end
  endfunction

  // decode one accepted byte into step_out and advance the model
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    logic [2:0] len;
    step_out.delete();
    if (dropping) begin
      // byte is thrown away
    end else if (rem_cont == 3'd0) begin
      casez (b)
        8'b0???????: len = 3'd1;
        8'b110?????: len = 3'd2;
        8'b1110????: len = 3'd3;
        8'b11110???: len = 3'd4;
        8'b111110??: len = 3'd5;
        8'b1111110?: len = 3'd6;
        default:     len = 3'd0;
      endcase
      if (b == 8'h00) begin
        dropping = 1'b1;
      end else if (len == 3'd0) begin
        note_error();
      end else begin
        seq_len = len;
        code_acc = {23'd0, b & ((len == 3'd1) ? 8'h7f : (8'hff >> (len + 3'd1)))};
        rem_cont = len - 3'd1;
        if (rem_cont == 3'd0) close_code();
      end
    end else if ((b & CONT_MASK) != CONT_TAG) begin
      note_error();
    end else begin
      code_acc = {code_acc[24:0], b[5:0]};
      rem_cont = rem_cont - 3'd1;
      if (rem_cont == 3'd0) close_code();
    end
    if (eos) begin
      if (!dropping && rem_cont != 3'd0) note_error();
      rem_cont = 3'd0;
      seq_len = 3'd0;
      code_acc = 31'd0;
      dropping = 1'b0;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one byte after a gap, return once the block took it
  task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input int row, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_string <= eos;
    cur_typed <= typed;
    cur_row <= row;
    do @(posedge clk); while (in_stall);
  endtask

  // both channels watched at the rising edge
  always @(posedge clk) begin
    logic in_beat;
    logic out_beat;
    unit_beat_t want;
    dir_row_t row;
    in_beat = rst_n && in_valid && !in_stall;
    out_beat = rst_n && out_valid && !out_stall;
    if (in_beat) begin
      decode_byte(in_data_byte, in_end_of_string);
      if (cur_typed) begin
        // directed row with its units written out by hand
        row = DIRECTED_ROWS[cur_row];
        for (int k = 0; k < int'(row.n); k++) begin
          want.unit = (k == 0) ? row.u0 : row.u1;
          want.err  = row.err;
          want.last = (k == int'(row.n) - 1);
          pending_units.insert(pending_units.size(), want);
        end
      end else begin
        foreach (step_out[k]) pending_units.insert(pending_units.size(), step_out[k]);
      end
    end
    if (out_beat) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got unit %h error %b last %b",
                 $time, out_code_unit, out_error, out_last_of_run);
        mismatches++;
      end else begin
        want = pending_units.pop_front();
        if (out_code_unit !== want.unit) begin
          $display("%0t: code unit, expected %h, got %h", $time, want.unit, out_code_unit);
          mismatches++;
        end
        if (out_error !== want.err) begin
          $display("%0t: error flag, expected %b, got %b", $time, want.err, out_error);
          mismatches++;
        end
        if (out_last_of_run !== want.last) begin
          $display("%0t: last of run, expected %b, got %b", $time, want.last,
                   out_last_of_run);
          mismatches++;
        end
      end
    end
    if (rst_n) quiet_cycles = (in_beat || out_beat) ? 0 : quiet_cycles + 1;
  end

  // hang detector
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // receiver: random stall pattern, one long hold when the random part starts
  initial begin
    int run_len;
    int stall_len;
    int r;
    logic held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      r = $urandom_range(0, 99);
      run_len = (r < 70) ? $urandom_range(1, 6) : $urandom_range(20, 100);
      r = $urandom_range(0, 99);
      if (r < 50) stall_len = 0;
      else if (r < 85) stall_len = $urandom_range(1, 3);
      else if (r < 97) stall_len = $urandom_range(4, 12);
      else stall_len = $urandom_range(30, 80);
      repeat (run_len) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat (stall_len) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0]  str_bytes[$];
    logic [7:0]  lead;
    logic [30:0] cp;
    int rand_sent;
    int nchars;
    int len;
    int r;
    int k;
    rand_sent = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].eos, DIRECTED_ROWS[i].typed, i,
                pick_gap());

    // random strings, mostly well formed, some damaged
    hold_go = 1'b1;
    while (rand_sent < RAND_BYTES) begin
      str_bytes.delete();
      nchars = $urandom_range(1, 8);
      for (int c = 0; c < nchars; c++) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          len = 1;
          cp = 31'($urandom_range(1, 127));
        end else if (r < 45) begin
          len = 2;
          cp = 31'($urandom_range(32'h80, 32'h7ff));
        end else if (r < 65) begin
          len = 3;
          cp = 31'($urandom_range(32'h800, 32'hffff));
          k = $urandom_range(0, 9);
          if (k == 0) cp = BOM_CODE;
          else if (k == 1) cp = 31'($urandom_range(32'hd800, 32'hdfff));
        end else if (r < 80) begin
          len = 4;
          if ($urandom_range(0, 7) == 0) cp = 31'($urandom_range(32'h110000, 32'h1fffff));
          else cp = 31'($urandom_range(32'h10000, 32'h10ffff));
        end else if (r < 85) begin
          len = 5;
          cp = 31'($urandom & 32'h03ffffff);
        end else if (r < 88) begin
          len = 6;
          cp = 31'($urandom & 32'h7fffffff);
        end else begin
          // small value in a form that may be longer than it needs
          len = $urandom_range(2, 6);
          cp = 31'($urandom_range(0, 255));
        end
        if (len == 1) begin
          str_bytes.insert(str_bytes.size(), {1'b0, cp[6:0]});
        end else begin
          lead = ~(8'hff >> len) | (8'(cp >> (6 * (len - 1))) & (8'hff >> (len + 1)));
          str_bytes.insert(str_bytes.size(), lead);
          for (k = len - 2; k >= 0; k--)
            str_bytes.insert(str_bytes.size(), 8'h80 | (8'(cp >> (6 * k)) & 8'h3f));
        end
      end

      // damage: cut short, random byte, terminator, bad lead, trailing noise
      r = $urandom_range(0, 99);
      if (r < 8) begin
        k = $urandom_range(1, 2);
        while (k > 0 && str_bytes.size() > 1) begin
          void'(str_bytes.pop_back());
          k--;
        end
      end else if (r < 16) begin
        str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (r < 22) begin
        str_bytes.insert($urandom_range(0, str_bytes.size() - 1), 8'h00);
      end else if (r < 27) begin
        str_bytes[$urandom_range(0, str_bytes.size() - 1)] =
          ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hfe, 8'hff))
                                      : 8'($urandom_range(8'h80, 8'hbf));
      end else if (r < 30) begin
        repeat ($urandom_range(1, 4))
          str_bytes.insert(str_bytes.size(), 8'($urandom_range(0, 255)));
      end

      foreach (str_bytes[j]) begin
        send_byte(str_bytes[j], j == str_bytes.size() - 1, 1'b0, 0,
                  (rand_sent < BURST_BYTES) ? 0 : pick_gap());
        rand_sent++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then wait on to catch stray beats
    while (pending_units.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
